// File: rtl/core/csi_pkg.sv
// ----------------------------------------------------------------------------
// csi_pkg
// Shared types and constants for the circle / segment intersection pipeline.
// ----------------------------------------------------------------------------
package csi_pkg;

   // Four divide lanes: first x, first y, second x, second y
   localparam int unsigned LANE_COUNT = 4;

   // Per-stage handshake between the top level and one cell of a chain
   typedef struct packed {
      logic advance;
      logic valid;
   } step_ctrl_type;

endpackage

// File: rtl/core/csi_if.sv
// ----------------------------------------------------------------------------
// csi_req_if / csi_rsp_if
// Valid/ready channels for circle-segment requests and intersection results.
// ----------------------------------------------------------------------------
interface csi_req_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic        [COORD_WIDTH-2:0] radius;
   logic signed [COORD_WIDTH-1:0] seg_start_x;
   logic signed [COORD_WIDTH-1:0] seg_start_y;
   logic signed [COORD_WIDTH-1:0] seg_end_x;
   logic signed [COORD_WIDTH-1:0] seg_end_y;

   modport source (
      output valid, center_x, center_y, radius,
      output seg_start_x, seg_start_y, seg_end_x, seg_end_y,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, radius,
      input  seg_start_x, seg_start_y, seg_end_x, seg_end_y,
      output ready
   );
endinterface

interface csi_rsp_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic        [1:0]             hit_count;
   logic                          first_valid;
   logic signed [COORD_WIDTH-1:0] first_x;
   logic signed [COORD_WIDTH-1:0] first_y;
   logic                          second_valid;
   logic signed [COORD_WIDTH-1:0] second_x;
   logic signed [COORD_WIDTH-1:0] second_y;

   modport source (
      output valid, hit_count, first_valid, first_x, first_y,
      output second_valid, second_x, second_y,
      input  ready
   );
   modport sink (
      input  valid, hit_count, first_valid, first_x, first_y,
      input  second_valid, second_x, second_y,
      output ready
   );
endinterface

// File: rtl/core/csi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// csi_sqrt_cell
// One digit of a pipelined integer square root: one trial subtract per cell.
// ----------------------------------------------------------------------------
module csi_sqrt_cell
   import csi_pkg::*;
#(
   parameter int RAD_WIDTH  = 134,
   parameter int SIDE_WIDTH = 8,
   parameter int STEP       = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  step_ctrl_type         ctrl,
   input  logic [RAD_WIDTH-1:0]  num_i,
   input  logic [RAD_WIDTH-1:0]  res_i,
   input  logic [SIDE_WIDTH-1:0] side_i,
   output logic                  valid_o,
   output logic [RAD_WIDTH-1:0]  num_o,
   output logic [RAD_WIDTH-1:0]  res_o,
   output logic [SIDE_WIDTH-1:0] side_o
);

   // Power of four handled by this cell
   localparam logic [RAD_WIDTH-1:0] BIT_WEIGHT =
      {{(RAD_WIDTH-1){1'b0}}, 1'b1} << (RAD_WIDTH - 2 - 2 * STEP);

   logic                  valid_ff;
   logic [RAD_WIDTH-1:0]  num_ff, num_in;
   logic [RAD_WIDTH-1:0]  res_ff, res_in;
   logic [SIDE_WIDTH-1:0] side_ff;
   logic [RAD_WIDTH-1:0]  trial;
   logic                  take;

   always_comb begin
      trial = res_i + BIT_WEIGHT;
      take  = (num_i >= trial);
      if (take) begin
         num_in = num_i - trial;
         res_in = (res_i >> 1) + BIT_WEIGHT;
      end else begin
         num_in = num_i;
         res_in = res_i >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         num_ff  <= num_in;
         res_ff  <= res_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign num_o   = num_ff;
   assign res_o   = res_ff;
   assign side_o  = side_ff;

endmodule

// File: rtl/core/csi_div_cell.sv
// ----------------------------------------------------------------------------
// csi_div_cell
// One quotient bit of four parallel restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module csi_div_cell
   import csi_pkg::*;
#(
   parameter int REM_WIDTH  = 104,
   parameter int DIV_WIDTH  = 68,
   parameter int QUO_WIDTH  = 33,
   parameter int SIDE_WIDTH = 8,
   parameter int STEP       = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  step_ctrl_type                         ctrl,
   input  logic [LANE_COUNT-1:0][REM_WIDTH-1:0]  rem_i,
   input  logic [LANE_COUNT-1:0][QUO_WIDTH-1:0]  quo_i,
   input  logic [DIV_WIDTH-1:0]                  dv_i,
   input  logic [SIDE_WIDTH-1:0]                 side_i,
   output logic                                  valid_o,
   output logic [LANE_COUNT-1:0][REM_WIDTH-1:0]  rem_o,
   output logic [LANE_COUNT-1:0][QUO_WIDTH-1:0]  quo_o,
   output logic [DIV_WIDTH-1:0]                  dv_o,
   output logic [SIDE_WIDTH-1:0]                 side_o
);

   // Quotient bit resolved by this cell
   localparam int SHIFT = QUO_WIDTH - 1 - STEP;

   logic                                 valid_ff;
   logic [LANE_COUNT-1:0][REM_WIDTH-1:0] rem_ff, rem_in;
   logic [LANE_COUNT-1:0][QUO_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_WIDTH-1:0]                 dv_ff;
   logic [SIDE_WIDTH-1:0]                side_ff;
   logic [REM_WIDTH-1:0]                 sub;

   always_comb begin
      sub = REM_WIDTH'(dv_i) << SHIFT;
      for (int l = 0; l < LANE_COUNT; l++) begin
         quo_in[l] = quo_i[l];
         if (rem_i[l] >= sub) begin
            rem_in[l]        = rem_i[l] - sub;
            quo_in[l][SHIFT] = 1'b1;
         end else begin
            rem_in[l] = rem_i[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dv_ff   <= dv_i;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign rem_o   = rem_ff;
   assign quo_o   = quo_ff;
   assign dv_o    = dv_ff;
   assign side_o  = side_ff;

endmodule

// File: rtl/core/circle_segment_intersection.sv
// ----------------------------------------------------------------------------
// circle_segment_intersection
// Fully pipelined circle / line-segment intersection, one request per cycle
// unless a stalled result fills every stage. Between request accept and
// result valid lie the square-root chain (one root bit per cell), the
// divide chain (one quotient bit per cell, four lanes side by side), and
// the wide products, each split into half-width partial products in one
// stage and summed in the next. Every stage holds its own valid bit and
// moves as soon as the stage after it has room, so a stalled result only
// backs up the pipeline, and a new request can be taken in any cycle in
// which some stage downstream is empty or the result is taken.
// ----------------------------------------------------------------------------
module circle_segment_intersection
   import csi_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   csi_req_if.sink   req_chan,
   csi_rsp_if.source rsp_chan
);

   localparam int W     = COORD_WIDTH;
   localparam int DW    = W + 1;
   localparam int PW    = 2 * DW + 2;
   localparam int HW    = 2 * PW;
   localparam int RW    = 4 * DW + 2;
   localparam int SW    = RW / 2;
   localparam int NW    = PW + 1;
   localparam int MPW   = DW + NW;
   localparam int RMW   = MPW + 1;
   localparam int QB    = DW;
   localparam int YW    = W + 2;
   localparam int HB    = PW / 2;
   localparam int PPW   = 2 * HB + 1;
   localparam int NHW   = NW - HB;
   localparam int PPM   = DW + NHW;

   localparam int FRONT = 6;
   localparam int SQ0   = FRONT;
   localparam int S5I   = SQ0 + SW;
   localparam int S6P   = S5I + 1;
   localparam int S6I   = S6P + 1;
   localparam int DV0   = S6I + 1;
   localparam int OUTI  = DV0 + QB;
   localparam int L     = OUTI + 1;

   localparam int LANE_FX = 0;
   localparam int LANE_FY = 1;
   localparam int LANE_SX = 2;
   localparam int LANE_SY = 3;

   localparam logic signed [YW-1:0] CMAX = YW'({1'b0, {(W-1){1'b1}}});
   localparam logic signed [YW-1:0] CMIN = ~CMAX;

   typedef struct packed {
      logic                 vert;
      logic signed [DW-1:0] dx, dy, fx, fy;
      logic [W-2:0]         r;
      logic signed [W-1:0]  sx, sy, ey, cy;
   } s0_type;

   typedef struct packed {
      logic                 vert;
      logic signed [PW-1:0] dxdx, dydy, fxdx, fydy, fxfx, fyfy, rr;
      logic signed [DW-1:0] dx, dy;
      logic signed [W-1:0]  sx, sy, ey, cy;
   } s1_type;

   typedef struct packed {
      logic                 vert;
      logic signed [PW-1:0] a, h, q, w;
      logic signed [DW-1:0] dx, dy;
      logic signed [W-1:0]  sx, sy, ey, cy;
   } s2_type;

   typedef struct packed {
      logic                   vert;
      logic [2*HB-1:0]        hh_ll, aq_ll;
      logic signed [PPW-1:0]  hh_lh, aq_lh, aq_hl;
      logic signed [2*HB-1:0] hh_hh, aq_hh;
      logic signed [PW-1:0]   w, h, a;
      logic signed [DW-1:0]   dx, dy;
      logic signed [W-1:0]    sx, sy, ey, cy;
   } s3p_type;

   typedef struct packed {
      logic                 vert;
      logic signed [HW-1:0] hh, aq;
      logic signed [PW-1:0] w, h, a;
      logic signed [DW-1:0] dx, dy;
      logic signed [W-1:0]  sx, sy, ey, cy;
   } s3_type;

   typedef struct packed {
      logic                 vert;
      logic                 neg;
      logic signed [PW-1:0] h, a;
      logic signed [DW-1:0] dx, dy;
      logic signed [W-1:0]  sx, sy, ey, cy;
   } sq_side_type;

   typedef struct packed {
      logic                 vert;
      logic                 ok0, ok1;
      logic signed [NW-1:0] n0, n1;
      logic signed [DW-1:0] dx, dy;
      logic signed [PW-1:0] a;
      logic signed [W-1:0]  sx, sy;
      logic signed [YW-1:0] vy0, vy1;
   } s5_type;

   typedef struct packed {
      logic                  vert;
      logic                  ok0, ok1;
      logic signed [PPM-1:0] x0_hi, x0_lo, y0_hi, y0_lo;
      logic signed [PPM-1:0] x1_hi, x1_lo, y1_hi, y1_lo;
      logic signed [PW-1:0]  a;
      logic signed [W-1:0]   sx, sy;
      logic signed [YW-1:0]  vy0, vy1;
   } s6p_type;

   typedef struct packed {
      logic                  vert;
      logic                  ok0, ok1;
      logic signed [MPW-1:0] px0, py0, px1, py1;
      logic signed [PW-1:0]  a;
      logic signed [W-1:0]   sx, sy;
      logic signed [YW-1:0]  vy0, vy1;
   } s6_type;

   typedef struct packed {
      logic                  vert;
      logic                  ok0, ok1;
      logic [LANE_COUNT-1:0] neg;
      logic signed [W-1:0]   sx, sy;
      logic signed [YW-1:0]  vy0, vy1;
   } dv_side_type;

   typedef struct packed {
      logic [1:0]          hit_count;
      logic                first_valid;
      logic signed [W-1:0] first_x, first_y;
      logic                second_valid;
      logic signed [W-1:0] second_x, second_y;
   } out_type;

   localparam int SQSW = $bits(sq_side_type);
   localparam int DVSW = $bits(dv_side_type);

   function automatic logic signed [W-1:0] sat_coord(input logic signed [YW-1:0] v);
      logic signed [YW-1:0] c;
      if (v > CMAX) begin
         c = CMAX;
      end else if (v < CMIN) begin
         c = CMIN;
      end else begin
         c = v;
      end
      return c[W-1:0];
   endfunction

   // ---------------------------------------------------------------- flow
   logic [L-1:0] stage_v;
   logic [L-1:0] en;

   // A stage advances when it or any stage after it has a hole, or the
   // result is taken.
   for (genvar k = 0; k < L; k++) begin : g_en
      localparam logic [L-1:0] LOW = (L'(1) << k) - L'(1);
      assign en[k] = rsp_chan.ready | ~(&(stage_v | LOW));
   end

   assign req_chan.ready = en[0];

   // ---------------------------------------------------------------- front
   logic [FRONT-1:0] fv_ff;
   s0_type  s0_ff, s0_in;
   s1_type  s1_ff, s1_in;
   s2_type  s2_ff, s2_in;
   s3p_type s3p_ff, s3p_in;
   s3_type  s3_ff, s3_in;
   logic [RW-1:0] rad4_ff, rad4_in;
   sq_side_type   side4_ff, side4_in;

   assign stage_v[FRONT-1:0] = fv_ff;

   logic signed [DW-1:0] cx_e, cy_e, sx_e, sy_e, ex_e, ey_e;
   assign cx_e = DW'(req_chan.center_x);
   assign cy_e = DW'(req_chan.center_y);
   assign sx_e = DW'(req_chan.seg_start_x);
   assign sy_e = DW'(req_chan.seg_start_y);
   assign ex_e = DW'(req_chan.seg_end_x);
   assign ey_e = DW'(req_chan.seg_end_y);

   always_comb begin
      s0_in.vert = (req_chan.seg_start_x == req_chan.seg_end_x);
      s0_in.dx   = ex_e - sx_e;
      s0_in.dy   = ey_e - sy_e;
      s0_in.fx   = sx_e - cx_e;
      s0_in.fy   = sy_e - cy_e;
      s0_in.r    = req_chan.radius;
      s0_in.sx   = req_chan.seg_start_x;
      s0_in.sy   = req_chan.seg_start_y;
      s0_in.ey   = req_chan.seg_end_y;
      s0_in.cy   = req_chan.center_y;
   end

   logic signed [PW-1:0] r_p;
   assign r_p = PW'(signed'({1'b0, s0_ff.r}));

   always_comb begin
      s1_in.vert = s0_ff.vert;
      s1_in.dxdx = PW'(s0_ff.dx) * PW'(s0_ff.dx);
      s1_in.dydy = PW'(s0_ff.dy) * PW'(s0_ff.dy);
      s1_in.fxdx = PW'(s0_ff.fx) * PW'(s0_ff.dx);
      s1_in.fydy = PW'(s0_ff.fy) * PW'(s0_ff.dy);
      s1_in.fxfx = PW'(s0_ff.fx) * PW'(s0_ff.fx);
      s1_in.fyfy = PW'(s0_ff.fy) * PW'(s0_ff.fy);
      s1_in.rr   = r_p * r_p;
      s1_in.dx   = s0_ff.dx;
      s1_in.dy   = s0_ff.dy;
      s1_in.sx   = s0_ff.sx;
      s1_in.sy   = s0_ff.sy;
      s1_in.ey   = s0_ff.ey;
      s1_in.cy   = s0_ff.cy;
   end

   always_comb begin
      s2_in.vert = s1_ff.vert;
      s2_in.a    = s1_ff.dxdx + s1_ff.dydy;
      s2_in.h    = s1_ff.fxdx + s1_ff.fydy;
      s2_in.q    = s1_ff.fxfx + s1_ff.fyfy - s1_ff.rr;
      s2_in.w    = s1_ff.rr - s1_ff.fxfx;
      s2_in.dx   = s1_ff.dx;
      s2_in.dy   = s1_ff.dy;
      s2_in.sx   = s1_ff.sx;
      s2_in.sy   = s1_ff.sy;
      s2_in.ey   = s1_ff.ey;
      s2_in.cy   = s1_ff.cy;
   end

   // Split h, a and q into a signed upper half and an unsigned lower half
   logic [HB-1:0]        h_lo, a_lo, q_lo;
   logic signed [HB-1:0] h_hi, a_hi, q_hi;
   assign h_lo = s2_ff.h[HB-1:0];
   assign a_lo = s2_ff.a[HB-1:0];
   assign q_lo = s2_ff.q[HB-1:0];
   assign h_hi = s2_ff.h[PW-1:HB];
   assign a_hi = s2_ff.a[PW-1:HB];
   assign q_hi = s2_ff.q[PW-1:HB];

   always_comb begin
      s3p_in.vert  = s2_ff.vert;
      s3p_in.hh_ll = h_lo * h_lo;
      s3p_in.hh_lh = signed'({1'b0, h_lo}) * h_hi;
      s3p_in.hh_hh = h_hi * h_hi;
      s3p_in.aq_ll = a_lo * q_lo;
      s3p_in.aq_lh = signed'({1'b0, a_lo}) * q_hi;
      s3p_in.aq_hl = signed'({1'b0, q_lo}) * a_hi;
      s3p_in.aq_hh = a_hi * q_hi;
      s3p_in.w     = s2_ff.w;
      s3p_in.h     = s2_ff.h;
      s3p_in.a     = s2_ff.a;
      s3p_in.dx    = s2_ff.dx;
      s3p_in.dy    = s2_ff.dy;
      s3p_in.sx    = s2_ff.sx;
      s3p_in.sy    = s2_ff.sy;
      s3p_in.ey    = s2_ff.ey;
      s3p_in.cy    = s2_ff.cy;
   end

   always_comb begin
      s3_in.vert = s3p_ff.vert;
      // h*h has two equal cross terms: add one shifted one place further
      s3_in.hh   = (HW'(s3p_ff.hh_hh) << (2 * HB)) + (HW'(s3p_ff.hh_lh) << (HB + 1)) +
                   HW'(s3p_ff.hh_ll);
      s3_in.aq   = (HW'(s3p_ff.aq_hh) << (2 * HB)) + (HW'(s3p_ff.aq_lh) << HB) +
                   (HW'(s3p_ff.aq_hl) << HB) + HW'(s3p_ff.aq_ll);
      s3_in.w    = s3p_ff.w;
      s3_in.h    = s3p_ff.h;
      s3_in.a    = s3p_ff.a;
      s3_in.dx   = s3p_ff.dx;
      s3_in.dy   = s3p_ff.dy;
      s3_in.sx   = s3p_ff.sx;
      s3_in.sy   = s3p_ff.sy;
      s3_in.ey   = s3p_ff.ey;
      s3_in.cy   = s3p_ff.cy;
   end

   logic signed [HW-1:0] rad_full;

   // Vertical segments take the root of r^2 - d^2, others the discriminant
   always_comb begin
      rad_full       = s3_ff.vert ? HW'(s3_ff.w) : (s3_ff.hh - s3_ff.aq);
      rad4_in        = rad_full[RW-1:0];
      side4_in.vert  = s3_ff.vert;
      side4_in.neg   = rad_full[HW-1];
      side4_in.h     = s3_ff.h;
      side4_in.a     = s3_ff.a;
      side4_in.dx    = s3_ff.dx;
      side4_in.dy    = s3_ff.dy;
      side4_in.sx    = s3_ff.sx;
      side4_in.sy    = s3_ff.sy;
      side4_in.ey    = s3_ff.ey;
      side4_in.cy    = s3_ff.cy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         if (en[0]) begin
            fv_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < FRONT; k++) begin
            if (en[k]) begin
               fv_ff[k] <= fv_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s0_ff <= s0_in;
      end
      if (en[1]) begin
         s1_ff <= s1_in;
      end
      if (en[2]) begin
         s2_ff <= s2_in;
      end
      if (en[3]) begin
         s3p_ff <= s3p_in;
      end
      if (en[4]) begin
         s3_ff <= s3_in;
      end
      if (en[5]) begin
         rad4_ff  <= rad4_in;
         side4_ff <= side4_in;
      end
   end

   // ---------------------------------------------------------------- sqrt
   logic [RW-1:0]   sq_num  [0:SW];
   logic [RW-1:0]   sq_res  [0:SW];
   logic [SQSW-1:0] sq_side [0:SW];

   assign sq_num[0]  = rad4_ff;
   assign sq_res[0]  = '0;
   assign sq_side[0] = side4_ff;

   for (genvar k = 0; k < SW; k++) begin : g_sqrt
      step_ctrl_type ctrl;
      assign ctrl.advance = en[SQ0+k];
      assign ctrl.valid   = stage_v[SQ0+k-1];
      csi_sqrt_cell #(
         .RAD_WIDTH  (RW),
         .SIDE_WIDTH (SQSW),
         .STEP       (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .num_i   (sq_num[k]),
         .res_i   (sq_res[k]),
         .side_i  (sq_side[k]),
         .valid_o (stage_v[SQ0+k]),
         .num_o   (sq_num[k+1]),
         .res_o   (sq_res[k+1]),
         .side_o  (sq_side[k+1])
      );
   end

   // ---------------------------------------------------------------- roots
   sq_side_type          sqo;
   logic [SW-1:0]        root;
   logic signed [NW-1:0] h_n, s_n, a_n, n_plus, n_minus;
   logic signed [YW-1:0] s_y, cy_y, ymin, ymax;
   logic                 okg0, okg1, okv0, okv1;
   logic                 v5_ff, v6p_ff, v6_ff;
   s5_type               s5_ff, s5_in;
   s6p_type              s6p_ff, s6p_in;
   s6_type               s6_ff, s6_in;
   logic signed [NHW-1:0] n0_hi, n0_lo, n1_hi, n1_lo;

   assign stage_v[S5I] = v5_ff;
   assign stage_v[S6P] = v6p_ff;
   assign stage_v[S6I] = v6_ff;

   always_comb begin
      sqo     = sq_side_type'(sq_side[SW]);
      root    = sq_res[SW][SW-1:0];
      h_n     = NW'(sqo.h);
      a_n     = NW'(sqo.a);
      s_n     = signed'(NW'(root));
      n_plus  = s_n - h_n;
      n_minus = -h_n - s_n;
      s_y     = signed'(YW'(root[W-1:0]));
      cy_y    = YW'(sqo.cy);
      ymin    = (sqo.sy < sqo.ey) ? YW'(sqo.sy) : YW'(sqo.ey);
      ymax    = (sqo.sy < sqo.ey) ? YW'(sqo.ey) : YW'(sqo.sy);

      s5_in.vert = sqo.vert;
      // Plus root is the one with the larger x
      if (sqo.dx[DW-1]) begin
         s5_in.n0 = n_minus;
         s5_in.n1 = n_plus;
      end else begin
         s5_in.n0 = n_plus;
         s5_in.n1 = n_minus;
      end
      s5_in.vy0 = cy_y + s_y;
      s5_in.vy1 = cy_y - s_y;
      okg0 = !s5_in.n0[NW-1] && (s5_in.n0 <= a_n);
      okg1 = !s5_in.n1[NW-1] && (s5_in.n1 <= a_n);
      okv0 = (s5_in.vy0 >= ymin) && (s5_in.vy0 <= ymax);
      okv1 = (s5_in.vy1 >= ymin) && (s5_in.vy1 <= ymax);
      s5_in.ok0 = !sqo.neg && (sqo.vert ? okv0 : okg0);
      s5_in.ok1 = !sqo.neg && (sqo.vert ? okv1 : okg1);
      s5_in.dx  = sqo.dx;
      s5_in.dy  = sqo.dy;
      s5_in.a   = sqo.a;
      s5_in.sx  = sqo.sx;
      s5_in.sy  = sqo.sy;
   end

   // Split each root numerator into a signed upper and an unsigned lower part
   assign n0_hi = s5_ff.n0[NW-1:HB];
   assign n1_hi = s5_ff.n1[NW-1:HB];
   assign n0_lo = signed'({1'b0, s5_ff.n0[HB-1:0]});
   assign n1_lo = signed'({1'b0, s5_ff.n1[HB-1:0]});

   always_comb begin
      s6p_in.vert  = s5_ff.vert;
      s6p_in.ok0   = s5_ff.ok0;
      s6p_in.ok1   = s5_ff.ok1;
      s6p_in.x0_hi = s5_ff.dx * n0_hi;
      s6p_in.x0_lo = s5_ff.dx * n0_lo;
      s6p_in.y0_hi = s5_ff.dy * n0_hi;
      s6p_in.y0_lo = s5_ff.dy * n0_lo;
      s6p_in.x1_hi = s5_ff.dx * n1_hi;
      s6p_in.x1_lo = s5_ff.dx * n1_lo;
      s6p_in.y1_hi = s5_ff.dy * n1_hi;
      s6p_in.y1_lo = s5_ff.dy * n1_lo;
      s6p_in.a     = s5_ff.a;
      s6p_in.sx    = s5_ff.sx;
      s6p_in.sy    = s5_ff.sy;
      s6p_in.vy0   = s5_ff.vy0;
      s6p_in.vy1   = s5_ff.vy1;
   end

   always_comb begin
      s6_in.vert = s6p_ff.vert;
      s6_in.ok0  = s6p_ff.ok0;
      s6_in.ok1  = s6p_ff.ok1;
      s6_in.px0  = (MPW'(s6p_ff.x0_hi) << HB) + MPW'(s6p_ff.x0_lo);
      s6_in.py0  = (MPW'(s6p_ff.y0_hi) << HB) + MPW'(s6p_ff.y0_lo);
      s6_in.px1  = (MPW'(s6p_ff.x1_hi) << HB) + MPW'(s6p_ff.x1_lo);
      s6_in.py1  = (MPW'(s6p_ff.y1_hi) << HB) + MPW'(s6p_ff.y1_lo);
      s6_in.a    = s6p_ff.a;
      s6_in.sx   = s6p_ff.sx;
      s6_in.sy   = s6p_ff.sy;
      s6_in.vy0  = s6p_ff.vy0;
      s6_in.vy1  = s6p_ff.vy1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         v6p_ff <= 1'b0;
         v6_ff  <= 1'b0;
      end else begin
         if (en[S5I]) begin
            v5_ff <= stage_v[S5I-1];
         end
         if (en[S6P]) begin
            v6p_ff <= v5_ff;
         end
         if (en[S6I]) begin
            v6_ff <= v6p_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[S5I]) begin
         s5_ff <= s5_in;
      end
      if (en[S6P]) begin
         s6p_ff <= s6p_in;
      end
      if (en[S6I]) begin
         s6_ff <= s6_in;
      end
   end

   // ---------------------------------------------------------------- divide
   // Rounded quotient: floor((2|p| + a) / 2a), sign applied afterwards
   logic [LANE_COUNT-1:0][RMW-1:0] dv_rem  [0:QB];
   logic [LANE_COUNT-1:0][QB-1:0]  dv_quo  [0:QB];
   logic [PW-1:0]                  dv_dv   [0:QB];
   logic [DVSW-1:0]                dv_side [0:QB];
   logic signed [MPW-1:0]          lane_p  [LANE_COUNT];
   logic [MPW-1:0]                 lane_mag;
   logic [LANE_COUNT-1:0][RMW-1:0] lane_rem;
   dv_side_type                    dvi;

   always_comb begin
      lane_p[LANE_FX] = s6_ff.px0;
      lane_p[LANE_FY] = s6_ff.py0;
      lane_p[LANE_SX] = s6_ff.px1;
      lane_p[LANE_SY] = s6_ff.py1;
      lane_mag        = '0;
      for (int l = 0; l < LANE_COUNT; l++) begin
         dvi.neg[l]  = lane_p[l][MPW-1];
         lane_mag    = lane_p[l][MPW-1] ? MPW'(-lane_p[l]) : MPW'(lane_p[l]);
         lane_rem[l] = (RMW'(lane_mag) << 1) + RMW'(s6_ff.a);
      end
      dvi.vert = s6_ff.vert;
      dvi.ok0  = s6_ff.ok0;
      dvi.ok1  = s6_ff.ok1;
      dvi.sx   = s6_ff.sx;
      dvi.sy   = s6_ff.sy;
      dvi.vy0  = s6_ff.vy0;
      dvi.vy1  = s6_ff.vy1;
   end

   assign dv_rem[0]  = lane_rem;
   assign dv_quo[0]  = '0;
   assign dv_dv[0]   = {s6_ff.a[PW-2:0], 1'b0};
   assign dv_side[0] = dvi;

   for (genvar k = 0; k < QB; k++) begin : g_div
      step_ctrl_type ctrl;
      assign ctrl.advance = en[DV0+k];
      assign ctrl.valid   = stage_v[DV0+k-1];
      csi_div_cell #(
         .REM_WIDTH  (RMW),
         .DIV_WIDTH  (PW),
         .QUO_WIDTH  (QB),
         .SIDE_WIDTH (DVSW),
         .STEP       (k)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .rem_i   (dv_rem[k]),
         .quo_i   (dv_quo[k]),
         .dv_i    (dv_dv[k]),
         .side_i  (dv_side[k]),
         .valid_o (stage_v[DV0+k]),
         .rem_o   (dv_rem[k+1]),
         .quo_o   (dv_quo[k+1]),
         .dv_o    (dv_dv[k+1]),
         .side_o  (dv_side[k+1])
      );
   end

   // ---------------------------------------------------------------- output
   dv_side_type          dvo;
   logic signed [YW-1:0] lane_v [LANE_COUNT];
   logic signed [YW-1:0] qv;
   logic signed [YW-1:0] x0, y0, x1, y1;
   logic                 vout_ff;
   out_type              out_ff, out_in;

   assign stage_v[OUTI] = vout_ff;

   always_comb begin
      dvo = dv_side_type'(dv_side[QB]);
      qv  = '0;
      for (int l = 0; l < LANE_COUNT; l++) begin
         qv        = signed'(YW'(dv_quo[QB][l]));
         lane_v[l] = dvo.neg[l] ? -qv : qv;
      end
      if (dvo.vert) begin
         x0 = YW'(dvo.sx);
         y0 = dvo.vy0;
         x1 = YW'(dvo.sx);
         y1 = dvo.vy1;
      end else begin
         x0 = YW'(dvo.sx) + lane_v[LANE_FX];
         y0 = YW'(dvo.sy) + lane_v[LANE_FY];
         x1 = YW'(dvo.sx) + lane_v[LANE_SX];
         y1 = YW'(dvo.sy) + lane_v[LANE_SY];
      end
      out_in.hit_count    = {1'b0, dvo.ok0} + {1'b0, dvo.ok1};
      out_in.first_valid  = dvo.ok0;
      out_in.second_valid = dvo.ok1;
      // Drop points that miss the segment
      out_in.first_x  = dvo.ok0 ? sat_coord(x0) : '0;
      out_in.first_y  = dvo.ok0 ? sat_coord(y0) : '0;
      out_in.second_x = dvo.ok1 ? sat_coord(x1) : '0;
      out_in.second_y = dvo.ok1 ? sat_coord(y1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vout_ff <= 1'b0;
      end else if (en[OUTI]) begin
         vout_ff <= stage_v[OUTI-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUTI]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_chan.valid        = vout_ff;
   assign rsp_chan.hit_count    = out_ff.hit_count;
   assign rsp_chan.first_valid  = out_ff.first_valid;
   assign rsp_chan.first_x      = out_ff.first_x;
   assign rsp_chan.first_y      = out_ff.first_y;
   assign rsp_chan.second_valid = out_ff.second_valid;
   assign rsp_chan.second_x     = out_ff.second_x;
   assign rsp_chan.second_y     = out_ff.second_y;

   // ---------------------------------------------------------------- checks
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.hit_count ==
         ({1'b0, rsp_chan.first_valid} + {1'b0, rsp_chan.second_valid}))
      else $error("hit count disagrees with point flags");

   a_first_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.first_valid |->
         rsp_chan.first_x == '0 && rsp_chan.first_y == '0)
      else $error("missed first point not zeroed");

   a_second_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.second_valid |->
         rsp_chan.second_x == '0 && rsp_chan.second_y == '0)
      else $error("missed second point not zeroed");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("request refused with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circle_segment_intersection. A short table of
// directed requests is followed by random ones; an accepted request with no
// known result goes through a bit-exact predictor; results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import csi_pkg::*;

   localparam int CW         = 32;
   localparam int ONE        = 65536;
   localparam int LATENCY    = 110;
   localparam int STALL_MAX  = 5000;
   localparam int RAND_ITEMS = 1500;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [CW-1:0] center_x;
      logic signed [CW-1:0] center_y;
      logic        [CW-2:0] radius;
      logic signed [CW-1:0] seg_start_x;
      logic signed [CW-1:0] seg_start_y;
      logic signed [CW-1:0] seg_end_x;
      logic signed [CW-1:0] seg_end_y;
   } probe_type;

   typedef struct {
      logic        [1:0]    hit_count;
      logic                 first_valid;
      logic signed [CW-1:0] first_x;
      logic signed [CW-1:0] first_y;
      logic                 second_valid;
      logic signed [CW-1:0] second_x;
      logic signed [CW-1:0] second_y;
   } hits_type;

   typedef struct {
      probe_type p;
      bit        known;
      hits_type  e;
   } row_type;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   bit   failed;
   int   quiet_cycles;

   csi_req_if #(.COORD_WIDTH(CW)) req_chan ();
   csi_rsp_if #(.COORD_WIDTH(CW)) rsp_chan ();

   circle_segment_intersection #(.COORD_WIDTH(CW)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // pending rows in send order, expected hits in accept order
   row_type  sent_rows[$];
   hits_type expected_hits[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic wide_type floor_sqrt(input wide_type w);
      logic [255:0] root;
      logic [255:0] cand;
      root = '0;
      for (int i = 127; i >= 0; i--) begin
         cand = root | (256'(1) << i);
         if (cand * cand <= 256'(w)) root = cand;
      end
      return wide_type'(root);
   endfunction

   // round to nearest, ties away from zero
   function automatic wide_type div_round(input wide_type num, input wide_type den);
      wide_type mag;
      wide_type quo;
      mag = (num < 0) ? -num : num;
      quo = (2 * mag + den) / (2 * den);
      return (num < 0) ? -quo : quo;
   endfunction

   function automatic logic signed [CW-1:0] clamp_coord(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = (wide_type'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v[CW-1:0];
   endfunction

   function automatic hits_type predict_hits(input probe_type p);
      wide_type cx, cy, r, sx, sy, ex, ey;
      wide_type d, w, yd, ymin, ymax;
      wide_type dx, dy, fx, fy, a, h, q, disc, s, tmp;
      wide_type n[2];
      wide_type px[2];
      wide_type py[2];
      bit       ok[2];
      hits_type res;
      cx = p.center_x;
      cy = p.center_y;
      r  = p.radius;
      sx = p.seg_start_x;
      sy = p.seg_start_y;
      ex = p.seg_end_x;
      ey = p.seg_end_y;
      ok = '{0, 0};
      px = '{0, 0};
      py = '{0, 0};
      if (sx == ex) begin
         d = sx - cx;
         w = r * r - d * d;
         if (w >= 0) begin
            yd   = floor_sqrt(w);
            ymin = (sy < ey) ? sy : ey;
            ymax = (sy < ey) ? ey : sy;
            n[0] = cy + yd;
            n[1] = cy - yd;
            for (int k = 0; k < 2; k++) begin
               if (n[k] >= ymin && n[k] <= ymax) begin
                  ok[k] = 1'b1;
                  px[k] = sx;
                  py[k] = n[k];
               end
            end
         end
      end else begin
         dx   = ex - sx;
         dy   = ey - sy;
         fx   = sx - cx;
         fy   = sy - cy;
         a    = dx * dx + dy * dy;
         h    = fx * dx + fy * dy;
         q    = fx * fx + fy * fy - r * r;
         disc = h * h - a * q;
         if (disc >= 0) begin
            s    = floor_sqrt(disc);
            n[0] = -h + s;
            n[1] = -h - s;
            // plus root is the one with the larger x
            if (dx < 0) begin
               tmp  = n[0];
               n[0] = n[1];
               n[1] = tmp;
            end
            for (int k = 0; k < 2; k++) begin
               if (n[k] >= 0 && n[k] <= a) begin
                  ok[k] = 1'b1;
                  px[k] = sx + div_round(dx * n[k], a);
                  py[k] = sy + div_round(dy * n[k], a);
               end
            end
         end
      end
      res.hit_count    = 2'(ok[0]) + 2'(ok[1]);
      res.first_valid  = ok[0];
      res.first_x      = clamp_coord(px[0]);
      res.first_y      = clamp_coord(py[0]);
      res.second_valid = ok[1];
      res.second_x     = clamp_coord(px[1]);
      res.second_y     = clamp_coord(py[1]);
      return res;
   endfunction

   function automatic probe_type make_probe(input longint cx, input longint cy,
                                            input longint r, input longint sx,
                                            input longint sy, input longint ex,
                                            input longint ey);
      probe_type p;
      p.center_x    = cx[CW-1:0];
      p.center_y    = cy[CW-1:0];
      p.radius      = r[CW-2:0];
      p.seg_start_x = sx[CW-1:0];
      p.seg_start_y = sy[CW-1:0];
      p.seg_end_x   = ex[CW-1:0];
      p.seg_end_y   = ey[CW-1:0];
      return p;
   endfunction

   function automatic hits_type make_hits(input int cnt, input bit v0, input longint x0,
                                          input longint y0, input bit v1,
                                          input longint x1, input longint y1);
      hits_type e;
      e.hit_count    = cnt[1:0];
      e.first_valid  = v0;
      e.first_x      = x0[CW-1:0];
      e.first_y      = y0[CW-1:0];
      e.second_valid = v1;
      e.second_x     = x1[CW-1:0];
      e.second_y     = y1[CW-1:0];
      return e;
   endfunction

   function automatic longint near(input longint base, input longint span);
      return base + longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   function automatic probe_type random_probe();
      probe_type p;
      longint cx, cy, r, sx, sy, ex, ey, reach;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         // noise over the full field range
         p.center_x    = $urandom;
         p.center_y    = $urandom;
         p.radius      = (CW-1)'($urandom);
         p.seg_start_x = $urandom;
         p.seg_start_y = $urandom;
         p.seg_end_x   = $urandom;
         p.seg_end_y   = $urandom;
         if (pick < 4) p.seg_end_x = p.seg_start_x;
         return p;
      end
      cx    = near(0, 200 * ONE);
      cy    = near(0, 200 * ONE);
      r     = $urandom_range(0, 60 * ONE);
      reach = 2 * r + ONE;
      sx    = near(cx, reach);
      sy    = near(cy, reach);
      ex    = near(cx, reach);
      ey    = near(cy, reach);
      if (pick < 30)      ex = sx;
      else if (pick < 33) begin
         ex = sx;
         ey = sy;
      end else if (pick < 40) ey = sy;
      return make_probe(cx, cy, r, sx, sy, ex, ey);
   endfunction

   task automatic send_probe(input probe_type p, input bit known, input hits_type e);
      row_type row;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      row.p     = p;
      row.known = known;
      row.e     = e;
      sent_rows = {sent_rows, row};
      req_chan.valid       <= 1'b1;
      req_chan.center_x    <= p.center_x;
      req_chan.center_y    <= p.center_y;
      req_chan.radius      <= p.radius;
      req_chan.seg_start_x <= p.seg_start_x;
      req_chan.seg_start_y <= p.seg_start_y;
      req_chan.seg_end_x   <= p.seg_end_x;
      req_chan.seg_end_y   <= p.seg_end_y;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // predict on request accept, check on result accept
   always @(posedge clock) begin
      row_type  row;
      hits_type exp_h;
      if (!reset && req_chan.valid && req_chan.ready) begin
         row   = sent_rows.pop_front();
         exp_h = row.known ? row.e : predict_hits(row.p);
         expected_hits = {expected_hits, exp_h};
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_hits.size() == 0) begin
            $error("unexpected result: hit_count %0d", rsp_chan.hit_count);
            failed = 1'b1;
         end else begin
            exp_h = expected_hits.pop_front();
            if (rsp_chan.hit_count !== exp_h.hit_count) begin
               $error("hit_count: expected %0d, actual %0d", exp_h.hit_count,
                      rsp_chan.hit_count);
               failed = 1'b1;
            end
            if (rsp_chan.first_valid !== exp_h.first_valid) begin
               $error("first_valid: expected %0d, actual %0d", exp_h.first_valid,
                      rsp_chan.first_valid);
               failed = 1'b1;
            end
            if (rsp_chan.first_x !== exp_h.first_x) begin
               $error("first_x: expected %0d, actual %0d", exp_h.first_x,
                      rsp_chan.first_x);
               failed = 1'b1;
            end
            if (rsp_chan.first_y !== exp_h.first_y) begin
               $error("first_y: expected %0d, actual %0d", exp_h.first_y,
                      rsp_chan.first_y);
               failed = 1'b1;
            end
            if (rsp_chan.second_valid !== exp_h.second_valid) begin
               $error("second_valid: expected %0d, actual %0d", exp_h.second_valid,
                      rsp_chan.second_valid);
               failed = 1'b1;
            end
            if (rsp_chan.second_x !== exp_h.second_x) begin
               $error("second_x: expected %0d, actual %0d", exp_h.second_x,
                      rsp_chan.second_x);
               failed = 1'b1;
            end
            if (rsp_chan.second_y !== exp_h.second_y) begin
               $error("second_y: expected %0d, actual %0d", exp_h.second_y,
                      rsp_chan.second_y);
               failed = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin
      row_type  rows[$];
      hits_type none;
      longint   mx, mn;
      mx   = 64'sh7FFFFFFF;
      mn   = -64'sh80000000;
      none = make_hits(0, 0, 0, 0, 0, 0, 0);

      failed         = 1'b0;
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.center_x    = '0;
      req_chan.center_y    = '0;
      req_chan.radius      = '0;
      req_chan.seg_start_x = '0;
      req_chan.seg_start_y = '0;
      req_chan.seg_end_x   = '0;
      req_chan.seg_end_y   = '0;
      rsp_chan.ready       = 1'b0;

      // vertical chord through the center
      rows = {rows, row_type'{make_probe(0, 0, ONE, 0, -2*ONE, 0, 2*ONE), 1,
                              make_hits(2, 1, 0, ONE, 1, 0, -ONE)}};
      // horizontal chord, both directions: plus root keeps the larger x
      rows = {rows, row_type'{make_probe(0, 0, ONE, -2*ONE, 0, 2*ONE, 0), 1,
                              make_hits(2, 1, ONE, 0, 1, -ONE, 0)}};
      rows = {rows, row_type'{make_probe(0, 0, ONE, 2*ONE, 0, -2*ONE, 0), 1,
                              make_hits(2, 1, ONE, 0, 1, -ONE, 0)}};
      // degenerate point segment on a zero circle
      rows = {rows, row_type'{make_probe(0, 0, 0, 0, 0, 0, 0), 1,
                              make_hits(2, 1, 0, 0, 1, 0, 0)}};
      // misses on both paths
      rows = {rows, row_type'{make_probe(0, 0, ONE, 5*ONE, -ONE, 5*ONE, ONE), 1, none}};
      rows = {rows, row_type'{make_probe(0, 0, ONE, -ONE, 5*ONE, ONE, 5*ONE), 1, none}};
      // inside, one crossing, tangents, diagonal
      rows = {rows, row_type'{make_probe(0, 0, 4*ONE, -ONE, 0, ONE, ONE), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, ONE, 0, 0, 3*ONE, ONE), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, ONE, -2*ONE, ONE, 2*ONE, ONE), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, ONE, ONE, -2*ONE, ONE, 2*ONE), 0, none}};
      rows = {rows, row_type'{make_probe(ONE/3, -ONE/7, 3*ONE, -5*ONE, -4*ONE,
                                         6*ONE, 5*ONE), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, 2*ONE, 0, 0, 0, 0), 1, none}};
      // field extremes and saturation
      rows = {rows, row_type'{make_probe(mx, mx, mx, mx, mx, mx, mx), 0, none}};
      rows = {rows, row_type'{make_probe(mn, mn, 0, mn, mn, mn, mn), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, mx, mn, mn, mx, mx), 0, none}};
      rows = {rows, row_type'{make_probe(0, 0, mx, mx, mn, mn, mx), 0, none}};
      rows = {rows, row_type'{make_probe(mn, mx, mx, mx, mn, mx, mx), 0, none}};
      rows = {rows, row_type'{make_probe(mx, mn, mx, mn, mx, mn, mn), 0, none}};
      rows = {rows, row_type'{make_probe(mn, 0, mx, mx, 0, mn, 0), 0, none}};
      rows = {rows, row_type'{make_probe(-1, -1, 1, -1, -2, -1, 0), 0, none}};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[i]) send_probe(rows[i].p, rows[i].known, rows[i].e);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         for (int i = 0; i < RAND_ITEMS / 4; i++) send_probe(random_probe(), 0, none);
      end
      req_chan.valid <= 1'b0;
      recv_stall_pct = 0;

      while (expected_hits.size() != 0 || sent_rows.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      if (!failed && expected_hits.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
